@@ design/sled_pkg.sv @@
// shared types, constants and helpers for the string literal escape decoder
`default_nettype none

package sled_pkg;

   // default configuration of the decoder
   localparam int MAX_ESC_DIGITS_DEF = 4;
   localparam int COUNT_WIDTH_DEF    = 16;

   // width of the reported length and newline fields
   localparam int RES_COUNT_W = 16;

   // result queue geometry
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   // characters with a special role
   localparam logic [7:0] CHAR_QUOTE = 8'h22;
   localparam logic [7:0] CHAR_BSL   = 8'h5c;
   localparam logic [7:0] CHAR_NL    = 8'h0a;
   localparam logic [7:0] CHAR_ZERO  = 8'h30;
   localparam logic [7:0] CHAR_ONE   = 8'h31;
   localparam logic [7:0] CHAR_SEVEN = 8'h37;
   localparam logic [7:0] CHAR_NINE  = 8'h39;
   localparam logic [7:0] CHAR_LC_X  = 8'h78;
   localparam logic [7:0] CHAR_UC_X  = 8'h58;

   typedef enum logic [2:0] {
      PH_OPEN,
      PH_TEXT,
      PH_BSL,
      PH_BSL0,
      PH_OCT,
      PH_HEX,
      PH_DEC
   } phase_type;

   typedef struct packed {
      logic [7:0]             out_byte;
      logic                   byte_valid;
      logic                   done_res;
      logic [RES_COUNT_W-1:0] raw_length;
      logic [RES_COUNT_W-1:0] newline_count;
      logic                   last_in_run;
   } result_type;

   // up to two results caused by one raw byte
   typedef struct packed {
      result_type  first;
      result_type  second;
      logic [1:0]  count;
   } step_out_type;

   // named escapes, case-insensitive; anything else stands for itself
   function automatic logic [7:0] named_escape(input logic [7:0] b);
      logic [7:0] r;
      r = b;
      case (b | 8'h20)
         8'h61: r = 8'h07;
         8'h62: r = 8'h08;
         8'h74: r = 8'h09;
         8'h6e: r = 8'h0a;
         8'h76: r = 8'h0b;
         8'h66: r = 8'h0c;
         8'h72: r = 8'h0d;
         default: r = b;
      endcase
      return r;
   endfunction

   function automatic logic is_hex(input logic [7:0] b);
      return (b inside {[8'h30:8'h39], [8'h41:8'h46], [8'h61:8'h66]});
   endfunction

   function automatic logic [3:0] hex_value(input logic [7:0] b);
      logic [3:0] r;
      if (b inside {[8'h30:8'h39]}) begin
         r = b[3:0];
      end else begin
         r = b[3:0] + 4'd9;
      end
      return r;
   endfunction

endpackage

`default_nettype wire

@@ design/sled_decode.sv @@
// escape state machine and counters: one raw byte in, up to two results out
`default_nettype none

module sled_decode #(
   parameter int MAX_ESC_DIGITS = sled_pkg::MAX_ESC_DIGITS_DEF,
   parameter int COUNT_WIDTH    = sled_pkg::COUNT_WIDTH_DEF
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  step,
   input  wire logic [7:0]            raw_byte,
   output sled_pkg::step_out_type     step_out
);
   import sled_pkg::*;

   localparam logic [2:0] DIGIT_LIMIT = 3'(MAX_ESC_DIGITS);

   phase_type              phase_ff, phase_in;
   logic [7:0]             value_ff, value_in;
   logic [2:0]             digits_ff, digits_in;
   logic [COUNT_WIDTH-1:0] length_ff, length_in;
   logic [COUNT_WIDTH-1:0] lines_ff, lines_in;

   logic [COUNT_WIDTH-1:0] length_inc;
   logic [COUNT_WIDTH-1:0] lines_inc;
   logic                   emit_esc;
   logic [7:0]             esc_byte;
   logic                   do_plain;
   logic                   have_direct;
   result_type             direct_res;
   result_type             esc_res;
   logic [7:0]             acc8;
   logic [7:0]             acc10;
   logic [7:0]             acc16;
   logic [2:0]             digits_next;

   assign length_inc  = (length_ff == '1) ? length_ff : length_ff + 1'b1;
   assign lines_inc   = (lines_ff == '1) ? lines_ff : lines_ff + 1'b1;
   assign acc8        = {value_ff[4:0], 3'b000} + {5'd0, raw_byte[2:0]};
   assign acc10       = 8'({value_ff, 3'b000} + {value_ff, 1'b0} + 11'(raw_byte[3:0]));
   assign acc16       = {value_ff[3:0], hex_value(raw_byte)};
   assign digits_next = digits_ff + 3'd1;

   always_comb begin
      phase_in    = phase_ff;
      value_in    = value_ff;
      digits_in   = digits_ff;
      length_in   = length_inc;
      lines_in    = lines_ff;
      emit_esc    = 1'b0;
      esc_byte    = value_ff;
      do_plain    = 1'b0;
      have_direct = 1'b0;
      direct_res  = '0;
      esc_res     = '0;
      step_out    = '0;

      case (phase_ff)
         PH_OPEN: begin
            phase_in = PH_TEXT;
         end
         PH_BSL: begin
            if (raw_byte == CHAR_ZERO) begin
               phase_in = PH_BSL0;
            end else if (raw_byte inside {[CHAR_ONE:CHAR_NINE]}) begin
               value_in  = {4'd0, raw_byte[3:0]};
               digits_in = 3'd1;
               phase_in  = PH_DEC;
               if (3'd1 >= DIGIT_LIMIT) begin
                  emit_esc = 1'b1;
                  esc_byte = {4'd0, raw_byte[3:0]};
               end
            end else if (raw_byte == CHAR_NL) begin
               phase_in = PH_TEXT;
            end else begin
               have_direct           = 1'b1;
               direct_res.out_byte   = named_escape(raw_byte);
               direct_res.byte_valid = 1'b1;
               phase_in              = PH_TEXT;
            end
         end
         PH_BSL0: begin
            if (raw_byte inside {[CHAR_ZERO:CHAR_SEVEN]}) begin
               value_in  = {5'd0, raw_byte[2:0]};
               digits_in = 3'd1;
               phase_in  = PH_OCT;
               if (3'd1 >= DIGIT_LIMIT) begin
                  emit_esc = 1'b1;
                  esc_byte = {5'd0, raw_byte[2:0]};
               end
            end else if (raw_byte == CHAR_LC_X || raw_byte == CHAR_UC_X) begin
               value_in  = 8'd0;
               digits_in = 3'd0;
               phase_in  = PH_HEX;
            end else begin
               emit_esc = 1'b1;
               esc_byte = 8'd0;
               do_plain = 1'b1;
            end
         end
         PH_OCT: begin
            if (raw_byte inside {[CHAR_ZERO:CHAR_SEVEN]}) begin
               value_in  = acc8;
               digits_in = digits_next;
               if (digits_next >= DIGIT_LIMIT) begin
                  emit_esc = 1'b1;
                  esc_byte = acc8;
               end
            end else begin
               emit_esc = 1'b1;
               do_plain = 1'b1;
            end
         end
         PH_HEX: begin
            if (is_hex(raw_byte)) begin
               value_in = acc16;
            end else begin
               emit_esc = 1'b1;
               do_plain = 1'b1;
            end
         end
         PH_DEC: begin
            if (raw_byte inside {[CHAR_ZERO:CHAR_NINE]}) begin
               value_in  = acc10;
               digits_in = digits_next;
               if (digits_next >= DIGIT_LIMIT) begin
                  emit_esc = 1'b1;
                  esc_byte = acc10;
               end
            end else begin
               emit_esc = 1'b1;
               do_plain = 1'b1;
            end
         end
         default: begin
            do_plain = 1'b1;
         end
      endcase

      // an emitted escape value clears the accumulator
      if (emit_esc) begin
         value_in  = 8'd0;
         digits_in = 3'd0;
         phase_in  = PH_TEXT;
         esc_res.out_byte   = esc_byte;
         esc_res.byte_valid = 1'b1;
      end

      // ordinary literal byte, possibly the one that ended an escape
      if (do_plain) begin
         phase_in = PH_TEXT;
         if (raw_byte == CHAR_NL) begin
            lines_in = lines_inc;
         end
         if (raw_byte == CHAR_QUOTE) begin
            have_direct              = 1'b1;
            direct_res.done_res      = 1'b1;
            direct_res.raw_length    = RES_COUNT_W'(length_inc);
            direct_res.newline_count = RES_COUNT_W'(lines_ff);
            phase_in                 = PH_OPEN;
            length_in                = '0;
            lines_in                 = '0;
         end else if (raw_byte == CHAR_BSL) begin
            phase_in = PH_BSL;
         end else begin
            have_direct           = 1'b1;
            direct_res.out_byte   = raw_byte;
            direct_res.byte_valid = 1'b1;
         end
      end

      if (emit_esc) begin
         step_out.first = esc_res;
         if (have_direct) begin
            step_out.second             = direct_res;
            step_out.second.last_in_run = 1'b1;
            step_out.count              = 2'd2;
         end else begin
            step_out.first.last_in_run = 1'b1;
            step_out.count             = 2'd1;
         end
      end else if (have_direct) begin
         step_out.first             = direct_res;
         step_out.first.last_in_run = 1'b1;
         step_out.count             = 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_OPEN;
         value_ff  <= 8'd0;
         digits_ff <= 3'd0;
         length_ff <= '0;
         lines_ff  <= '0;
      end else if (step) begin
         phase_ff  <= phase_in;
         value_ff  <= value_in;
         digits_ff <= digits_in;
         length_ff <= length_in;
         lines_ff  <= lines_in;
      end
   end

endmodule

`default_nettype wire

@@ design/sled_resp_queue.sv @@
// result queue: takes up to two results a cycle, hands out one per beat
`default_nettype none

module sled_resp_queue (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire sled_pkg::step_out_type push_data,
   input  wire logic                  push,
   output logic                       room,
   output logic                       out_valid,
   input  wire logic                  out_take,
   output sled_pkg::result_type       out_data
);
   import sled_pkg::*;

   result_type          entry_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]   count_ff, count_in;
   logic [1:0]          push_n;
   logic                pop;
   logic [QPTR_W-1:0]   wr_ptr_p1;

   assign push_n    = push ? push_data.count : 2'd0;
   assign pop       = out_valid && out_take;
   assign wr_ptr_p1 = wr_ptr_ff + 1'b1;

   // room for a full two-result step
   assign room      = (count_ff <= QCNT_W'(QUEUE_DEPTH - 2));
   assign out_valid = (count_ff != '0);
   assign out_data  = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff + QPTR_W'(push_n);
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff + QCNT_W'(push_n) - QCNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (push_n != 2'd0) begin
         entry_ff[wr_ptr_ff] <= push_data.first;
      end
      if (push_n == 2'd2) begin
         entry_ff[wr_ptr_p1] <= push_data.second;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

`default_nettype wire

@@ design/string_literal_escape_decoder.sv @@
// top level of the string literal escape decoder
`default_nettype none

// Decodes the raw bytes of one double-quoted literal at a time. The first beat of
// a literal is the opening quote and is skipped; every later beat yields zero,
// one or two result beats: the decoded byte, an escape value that the beat
// terminated followed by the beat's own byte, or the closing report. The close
// (an unescaped quote) gives one beat with done_res set, carrying the raw length
// including both quotes and the count of raw newlines outside escapes, both
// saturating at COUNT_WIDTH bits and shown as their low 16 bits; the counters
// then clear and the next beat opens a new literal. Supported escapes: \0 with
// up to MAX_ESC_DIGITS octal digits, \0x or \0X with any number of hex digits,
// \1..\9 with up to MAX_ESC_DIGITS decimal digits, all taken mod 256; backslash
// newline is dropped; a b t n v f r in either case; any other byte after a
// backslash stands for itself. last_in_run marks the final result beat of each
// input beat. Timing: a request beat lands in an input register; once the
// result queue has room for two results, the escape state machine decodes it
// in a single pass and writes its results into a four-entry result queue. One
// beat per cycle is sustained as long as each beat gives at most one result
// and the response side does not stall; the result queue drains one beat per
// cycle while the response side does not stall, so a beat that yields two
// results takes two output beats. No startup sweep is needed after reset.

module string_literal_escape_decoder #(
   parameter int MAX_ESC_DIGITS = sled_pkg::MAX_ESC_DIGITS_DEF,
   parameter int COUNT_WIDTH    = sled_pkg::COUNT_WIDTH_DEF
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   // request channel
   input  wire logic                              req_valid,
   output logic                                   req_stall,
   input  wire logic [7:0]                        req_raw_byte,
   // response channel
   output logic                                   rsp_valid,
   input  wire logic                              rsp_stall,
   output logic [7:0]                             rsp_out_byte,
   output logic                                   rsp_byte_valid,
   output logic                                   rsp_done_res,
   output logic [sled_pkg::RES_COUNT_W-1:0]       rsp_raw_length,
   output logic [sled_pkg::RES_COUNT_W-1:0]       rsp_newline_count,
   output logic                                   rsp_last_in_run
);
   import sled_pkg::*;

   // input register
   logic         req_full_ff, req_full_in;
   logic [7:0]   req_byte_ff;
   logic         req_take;

   // decode and queue hookup
   logic         advance;
   logic         room;
   step_out_type step_out;
   result_type   head;

   // the registered beat moves into the decoder when the queue can hold
   // its worst case of two results
   assign advance   = req_full_ff && room;
   assign req_stall = req_full_ff && !room;
   assign req_take  = req_valid && !req_stall;

   always_comb begin
      req_full_in = req_full_ff;
      if (req_take) begin
         req_full_in = 1'b1;
      end else if (advance) begin
         req_full_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         req_full_ff <= 1'b0;
      end else begin
         req_full_ff <= req_full_in;
      end
   end

   // payload register, no reset needed
   always_ff @(posedge clock) begin
      if (req_take) begin
         req_byte_ff <= req_raw_byte;
      end
   end

   // escape state machine and counters
   sled_decode #(
      .MAX_ESC_DIGITS (MAX_ESC_DIGITS),
      .COUNT_WIDTH    (COUNT_WIDTH)
   ) u_decode (
      .clock    (clock),
      .reset    (reset),
      .step     (advance),
      .raw_byte (req_byte_ff),
      .step_out (step_out)
   );

   // results wait here until the response side takes them
   sled_resp_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push_data (step_out),
      .push      (advance),
      .room      (room),
      .out_valid (rsp_valid),
      .out_take  (!rsp_stall),
      .out_data  (head)
   );

   assign rsp_out_byte      = head.out_byte;
   assign rsp_byte_valid    = head.byte_valid;
   assign rsp_done_res      = head.done_res;
   assign rsp_raw_length    = head.raw_length;
   assign rsp_newline_count = head.newline_count;
   assign rsp_last_in_run   = head.last_in_run;

endmodule

`default_nettype wire
